@@ hw/rtl/multi_slot_countdown_timer_table_defines.svh @@
// assertion macros for the timer table checker
// no dependencies
`ifndef MULTI_SLOT_COUNTDOWN_TIMER_TABLE_DEFINES_SVH
`define MULTI_SLOT_COUNTDOWN_TIMER_TABLE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPL(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
// next-cycle implication
`define CHK_NEXT(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`endif

@@ hw/rtl/mct_pkg.sv @@
// shared types and constants of the timer table
// no dependencies
package mct_pkg;
	localparam int unsigned SLOTS = 16;
	localparam int unsigned IDX_W = $clog2(SLOTS);
	localparam int unsigned CNT_W = $clog2(SLOTS + 1);

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;
	localparam logic [1:0] KIND_TICK = 2'd3;

	localparam logic [2:0] UNIT_S = 3'd1;
	localparam logic [2:0] UNIT_MIN = 3'd2;
	localparam logic [2:0] UNIT_H = 3'd3;
	localparam logic [2:0] UNIT_DAY = 3'd4;

	localparam logic [15:0] HEARTBEAT_RESET = 16'd1000;

	typedef struct packed {
		logic [1:0] kind;
		logic [15:0] handler_id;
		logic [15:0] context_id;
		logic [31:0] delay;
		logic [2:0] unit_code;
		logic repeat_req;
		logic urgent;
		logic [15:0] elapsed_ms;
	} cmd_t;

	typedef struct packed {
		logic is_wake;
		logic [15:0] woken_handler;
		logic [15:0] woken_context;
		logic woken_urgent;
		logic ok;
		logic [15:0] next_interval;
		logic [5:0] active_count;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [15:0] handler;
		logic [15:0] context_id;
		logic [31:0] duration;
		logic [31:0] remaining;
		logic rep;
		logic urg;
	} slot_t;

	// factor for the unit, zero for plain ms and for unused codes
	function automatic logic [31:0] unit_factor(input logic [2:0] u);
		logic [31:0] f;
		begin
			case (u)
				UNIT_S: f = 32'd1000;
				UNIT_MIN: f = 32'd60000;
				UNIT_H: f = 32'd3600000;
				UNIT_DAY: f = 32'd86400000;
				default: f = 32'd0;
			endcase
			return f;
		end
	endfunction

	function automatic logic [31:0] unit_limit(input logic [2:0] u);
		logic [31:0] l;
		begin
			case (u)
				UNIT_S: l = 32'hFFFF_FFFF / 32'd1000;
				UNIT_MIN: l = 32'hFFFF_FFFF / 32'd60000;
				UNIT_H: l = 32'hFFFF_FFFF / 32'd3600000;
				UNIT_DAY: l = 32'hFFFF_FFFF / 32'd86400000;
				default: l = 32'd0;
			endcase
			return l;
		end
	endfunction
endpackage

@@ hw/rtl/mct_stream_if.sv @@
// valid/ready channel carrying one item
// depends on mct_pkg for nothing; payload width is a type parameter
interface mct_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/mct_conv.sv @@
// delay to ms conversion, one multiply registered
// depends on mct_pkg
module mct_conv (
	input logic clk,
	input logic [31:0] delay,
	input logic [2:0] unit_code,
	output logic [31:0] ms_q
);
	logic [31:0] f;
	logic [31:0] prod;
	always_comb begin
		f = mct_pkg::unit_factor(unit_code);
		prod = delay * f;
	end
	always_ff @(posedge clk) begin
		if (f != 32'd0 && delay <= mct_pkg::unit_limit(unit_code)) begin
			ms_q <= prod;
		end else begin
			ms_q <= delay;
		end
	end
endmodule

@@ hw/rtl/multi_slot_countdown_timer_table.sv @@
// timer table top level: sequencer walking the slot memory with one shared unit
// depends on mct_pkg, mct_stream_if, mct_conv
//
// channel | dir | payload
// in      | in  | kind, handler_id, context_id, delay, unit_code, repeat_req, urgent, elapsed_ms
// out     | out | is_wake, woken_handler, woken_context, woken_urgent, ok, next_interval,
//         |     | active_count, last
//
// one item at a time: a conversion step, a memory read and at most one write per slot visited
// and once more to close the walk, a read and a write for each slot moved into a freed place,
// an interval refresh walk after a tick or a successful add or restart, and the status result.
// reset clears control and count, sets heartbeat and interval to 1000; slots need no clearing.
// a waiting result holds the input, and the walk at a wake or the status, until it is taken.
module multi_slot_countdown_timer_table (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	mct_stream_if.sink in,
	mct_stream_if.source out
);
	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_CONV = 10'b0000000010,
		ST_RD = 10'b0000000100,
		ST_EXEC = 10'b0000001000,
		ST_MOVE = 10'b0000010000,
		ST_MVWR = 10'b0000100000,
		ST_WAKE = 10'b0001000000,
		ST_RFRD = 10'b0010000000,
		ST_RFEX = 10'b0100000000,
		ST_STAT = 10'b1000000000
	} state_t;

	state_t state_q;
	mct_pkg::cmd_t cmd_q;
	logic [15:0] heartbeat_q;
	logic [15:0] interval_q;
	logic [mct_pkg::CNT_W-1:0] count_q;
	logic [mct_pkg::CNT_W-1:0] idx_q;
	logic ok_q;
	logic refresh_q;
	logic [31:0] ms;
	logic [31:0] best_q;
	mct_pkg::slot_t mem [mct_pkg::SLOTS];
	mct_pkg::slot_t rd_q;
	mct_pkg::slot_t wr_data;
	logic wr_en;
	logic [mct_pkg::IDX_W-1:0] wr_addr;
	logic [mct_pkg::IDX_W-1:0] rd_addr;
	mct_pkg::rsp_t rsp_q;
	logic out_v_q;
	logic [mct_pkg::IDX_W-1:0] mv_dst_q;
	logic mv_wake_q;
	logic [31:0] sub_res;
	logic [15:0] cap;

	mct_conv u_conv (
		.clk(clk),
		.delay(cmd_q.delay),
		.unit_code(cmd_q.unit_code),
		.ms_q(ms)
	);

	assign cap = (heartbeat_q == 16'd0) ? 16'd1 : heartbeat_q;
	assign in.ready = (state_q == ST_IDLE) && !out_v_q;
	assign out.valid = out_v_q;
	assign out.data = rsp_q;

	// shared subtract unit
	always_comb begin
		if (cmd_q.kind == mct_pkg::KIND_ADD) begin
			sub_res = (rd_q.remaining > {16'd0, cmd_q.elapsed_ms})
				? rd_q.remaining - {16'd0, cmd_q.elapsed_ms} : 32'd0;
		end else begin
			sub_res = rd_q.remaining - {16'd0, interval_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		rd_addr = idx_q[mct_pkg::IDX_W-1:0];
		if (state_q == ST_MOVE) begin
			rd_addr = mct_pkg::IDX_W'(count_q - 1'b1);
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = idx_q[mct_pkg::IDX_W-1:0];
		wr_data = rd_q;
		unique case (state_q)
			ST_EXEC: begin
				if (idx_q == count_q) begin
					wr_en = (cmd_q.kind == mct_pkg::KIND_ADD) && ms != 32'd0
						&& count_q < mct_pkg::CNT_W'(mct_pkg::SLOTS);
					wr_data.handler = cmd_q.handler_id;
					wr_data.context_id = cmd_q.context_id;
					wr_data.duration = ms;
					wr_data.remaining = ms;
					wr_data.rep = cmd_q.repeat_req;
					wr_data.urg = cmd_q.urgent;
				end else if (cmd_q.kind == mct_pkg::KIND_ADD) begin
					wr_en = ms != 32'd0 && count_q < mct_pkg::CNT_W'(mct_pkg::SLOTS);
					wr_data.remaining = sub_res;
				end else if (cmd_q.kind == mct_pkg::KIND_RESTART) begin
					wr_en = rd_q.handler == cmd_q.handler_id
						&& rd_q.context_id == cmd_q.context_id && rd_q.duration == ms;
					wr_data.remaining = rd_q.duration;
				end else if (cmd_q.kind == mct_pkg::KIND_TICK) begin
					if (rd_q.remaining <= {16'd0, interval_q}) begin
						wr_en = rd_q.rep && !out_v_q;
						wr_data.remaining = rd_q.duration;
					end else begin
						wr_en = 1'b1;
						wr_data.remaining = sub_res;
					end
				end
			end
			ST_MVWR: begin
				wr_en = 1'b1;
				wr_addr = mv_dst_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q <= '0;
			heartbeat_q <= mct_pkg::HEARTBEAT_RESET;
			interval_q <= mct_pkg::HEARTBEAT_RESET;
			count_q <= '0;
			idx_q <= '0;
			out_v_q <= 1'b0;
			rsp_q <= '0;
			ok_q <= 1'b0;
			refresh_q <= 1'b0;
			best_q <= '0;
			mv_dst_q <= '0;
			mv_wake_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				heartbeat_q <= cfg_wdata;
			end
			if (out_v_q && out.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in.valid && in.ready) begin
						cmd_q <= in.data;
						idx_q <= '0;
						ok_q <= 1'b0;
						refresh_q <= 1'b0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: state_q <= ST_RD;
				ST_RD: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (idx_q == count_q) begin
						if (cmd_q.kind == mct_pkg::KIND_ADD) begin
							if (ms != 32'd0 && count_q < mct_pkg::CNT_W'(mct_pkg::SLOTS)) begin
								count_q <= count_q + 1'b1;
								ok_q <= 1'b1;
								refresh_q <= 1'b1;
							end
						end else if (cmd_q.kind == mct_pkg::KIND_TICK) begin
							ok_q <= 1'b1;
							refresh_q <= 1'b1;
						end
						state_q <= ST_RFRD;
					end else if (cmd_q.kind == mct_pkg::KIND_ADD) begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_RD;
					end else if (cmd_q.kind == mct_pkg::KIND_TICK) begin
						if (rd_q.remaining <= {16'd0, interval_q}) begin
							if (!out_v_q) begin
								rsp_q <= '{is_wake: 1'b1, woken_handler: rd_q.handler,
									woken_context: rd_q.context_id, woken_urgent: rd_q.urg,
									default: '0};
								out_v_q <= 1'b1;
								if (rd_q.rep) begin
									idx_q <= idx_q + 1'b1;
									state_q <= ST_RD;
								end else begin
									mv_dst_q <= idx_q[mct_pkg::IDX_W-1:0];
									mv_wake_q <= 1'b1;
									state_q <= ST_MOVE;
								end
							end
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_RD;
						end
					end else if (rd_q.handler == cmd_q.handler_id
						&& rd_q.context_id == cmd_q.context_id && rd_q.duration == ms) begin
						ok_q <= 1'b1;
						if (cmd_q.kind == mct_pkg::KIND_RESTART) begin
							refresh_q <= 1'b1;
							state_q <= ST_RFRD;
						end else begin
							mv_dst_q <= idx_q[mct_pkg::IDX_W-1:0];
							mv_wake_q <= 1'b0;
							state_q <= ST_MOVE;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_MOVE: begin
					count_q <= count_q - 1'b1;
					state_q <= ST_MVWR;
				end
				ST_MVWR: begin
					if (mv_wake_q) begin
						state_q <= ST_RD;
					end else begin
						state_q <= ST_RFRD;
					end
				end
				ST_RFRD: begin
					best_q <= {16'd0, cap};
					idx_q <= '0;
					if (refresh_q) begin
						state_q <= ST_RFEX;
					end else begin
						state_q <= ST_STAT;
					end
				end
				ST_RFEX: begin
					if (idx_q == count_q + 1'b1 || idx_q == '0 && count_q == '0) begin
						interval_q <= best_q[15:0];
						state_q <= ST_STAT;
					end else begin
						if (idx_q != '0 && rd_q.remaining != 32'd0 && rd_q.remaining < best_q) begin
							best_q <= rd_q.remaining;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_STAT: begin
					if (!out_v_q) begin
						rsp_q <= '{ok: ok_q, next_interval: interval_q,
							active_count: 6'(count_q), last: 1'b1, default: '0};
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/mct_checker.sv @@
// port-level checks of the timer table
// depends on mct_pkg and the defines header
`include "multi_slot_countdown_timer_table_defines.svh"
module mct_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input mct_pkg::rsp_t out_data
);
	`CHK_IMPL(a_no_accept_busy, clk, arst_n, out_valid, !in_ready)
	`CHK_IMPL(a_wake_fields, clk, arst_n, out_valid && out_data.is_wake, !out_data.last && !out_data.ok)
	`CHK_IMPL(a_status_last, clk, arst_n, out_valid && !out_data.is_wake, out_data.last && out_data.next_interval != 16'd0)
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`CHK_IMPL(a_count_range, clk, arst_n, out_valid && out_data.last, out_data.active_count <= 6'(mct_pkg::SLOTS))
endmodule

bind multi_slot_countdown_timer_table mct_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in.valid),
	.in_ready(in.ready),
	.out_valid(out.valid),
	.out_ready(out.ready),
	.out_data(out.data)
);

@@ verif/mct_tb_if.sv @@
// testbench-side types: the channel interface comes from the rtl (mct_stream_if)
// depends on mct_pkg only for the payload types used by the testbench
package mct_tb_pkg;
	typedef mct_pkg::rsp_t rsp_q_t[$];
endpackage

@@ verif/testbench.sv @@
// testbench for multi_slot_countdown_timer_table: directed and random items, a timer
// table predictor and an in-order scoreboard; depends on mct_pkg, mct_stream_if, mct_tb_pkg

class timer_scoreboard;
	logic [15:0] s_handler[mct_pkg::SLOTS];
	logic [15:0] s_context[mct_pkg::SLOTS];
	logic [31:0] s_duration[mct_pkg::SLOTS];
	logic [31:0] s_remaining[mct_pkg::SLOTS];
	logic s_rep[mct_pkg::SLOTS];
	logic s_urg[mct_pkg::SLOTS];
	int unsigned count;
	logic [31:0] interval;
	logic [15:0] heartbeat;
	mct_tb_pkg::rsp_q_t pending;
	int errors;

	function new();
		count = 0;
		interval = 1000;
		heartbeat = mct_pkg::HEARTBEAT_RESET;
		errors = 0;
	endfunction

	function logic [31:0] to_ms(logic [31:0] d, logic [2:0] u);
		logic [31:0] f;
		case (u)
			mct_pkg::UNIT_S: f = 1000;
			mct_pkg::UNIT_MIN: f = 60000;
			mct_pkg::UNIT_H: f = 3600000;
			mct_pkg::UNIT_DAY: f = 86400000;
			default: f = 0;
		endcase
		if (f == 0)
			return d;
		if (d <= 32'hFFFF_FFFF / f)
			return d * f;
		return d;
	endfunction

	function void refresh();
		interval = (heartbeat == 0) ? 1 : heartbeat;
		for (int i = 0; i < count; i++)
			if (s_remaining[i] > 0 && s_remaining[i] < interval)
				interval = s_remaining[i];
	endfunction

	function void drop(int i);
		count--;
		s_handler[i] = s_handler[count];
		s_context[i] = s_context[count];
		s_duration[i] = s_duration[count];
		s_remaining[i] = s_remaining[count];
		s_rep[i] = s_rep[count];
		s_urg[i] = s_urg[count];
	endfunction

	function int find(mct_pkg::cmd_t c);
		logic [31:0] ms;
		ms = to_ms(c.delay, c.unit_code);
		for (int i = 0; i < count; i++)
			if (s_handler[i] == c.handler_id && s_context[i] == c.context_id &&
					s_duration[i] == ms)
				return i;
		return -1;
	endfunction

	function void note_item(mct_pkg::cmd_t c);
		mct_pkg::rsp_t r;
		logic [31:0] ms;
		logic ok;
		int m;
		int i;
		ok = 0;
		case (c.kind)
			mct_pkg::KIND_ADD: begin
				ms = to_ms(c.delay, c.unit_code);
				if (ms != 0 && count < mct_pkg::SLOTS) begin
					for (int k = 0; k < count; k++)
						s_remaining[k] = (s_remaining[k] > c.elapsed_ms) ?
							s_remaining[k] - c.elapsed_ms : 0;
					s_handler[count] = c.handler_id;
					s_context[count] = c.context_id;
					s_duration[count] = ms;
					s_remaining[count] = ms;
					s_rep[count] = c.repeat_req;
					s_urg[count] = c.urgent;
					count++;
					refresh();
					ok = 1;
				end
			end
			mct_pkg::KIND_CANCEL: begin
				m = find(c);
				if (m >= 0) begin
					drop(m);
					ok = 1;
				end
			end
			mct_pkg::KIND_RESTART: begin
				m = find(c);
				if (m >= 0) begin
					s_remaining[m] = s_duration[m];
					refresh();
					ok = 1;
				end
			end
			default: begin
				i = 0;
				while (i < count) begin
					if (s_remaining[i] <= interval) begin
						r = '0;
						r.is_wake = 1;
						r.woken_handler = s_handler[i];
						r.woken_context = s_context[i];
						r.woken_urgent = s_urg[i];
						pending.push_back(r);
						if (s_rep[i]) begin
							s_remaining[i] = s_duration[i];
							i++;
						end else
							drop(i);
					end else begin
						s_remaining[i] -= interval;
						i++;
					end
				end
				refresh();
				ok = 1;
			end
		endcase
		r = '0;
		r.ok = ok;
		r.next_interval = interval[15:0];
		r.active_count = 6'(count);
		r.last = 1;
		pending.push_back(r);
	endfunction

	function void check_result(mct_pkg::rsp_t a);
		mct_pkg::rsp_t e;
		if (pending.size() == 0) begin
			$error("unexpected result %h", a);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (a.is_wake !== e.is_wake) begin
			$error("is_wake exp %0d got %0d", e.is_wake, a.is_wake);
			errors++;
		end
		if (a.woken_handler !== e.woken_handler) begin
			$error("woken_handler exp %0d got %0d", e.woken_handler, a.woken_handler);
			errors++;
		end
		if (a.woken_context !== e.woken_context) begin
			$error("woken_context exp %0d got %0d", e.woken_context, a.woken_context);
			errors++;
		end
		if (a.woken_urgent !== e.woken_urgent) begin
			$error("woken_urgent exp %0d got %0d", e.woken_urgent, a.woken_urgent);
			errors++;
		end
		if (a.ok !== e.ok) begin
			$error("ok exp %0d got %0d", e.ok, a.ok);
			errors++;
		end
		if (a.next_interval !== e.next_interval) begin
			$error("next_interval exp %0d got %0d", e.next_interval, a.next_interval);
			errors++;
		end
		if (a.active_count !== e.active_count) begin
			$error("active_count exp %0d got %0d", e.active_count, a.active_count);
			errors++;
		end
		if (a.last !== e.last) begin
			$error("last exp %0d got %0d", e.last, a.last);
			errors++;
		end
	endfunction
endclass

module testbench;
	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;
	logic calm;
	timer_scoreboard board;

	mct_stream_if #(.T(mct_pkg::cmd_t)) in_ch ();
	mct_stream_if #(.T(mct_pkg::rsp_t)) out_ch ();

	multi_slot_countdown_timer_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in(in_ch.sink),
		.out(out_ch.source)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		board = new();
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		calm = 1'b0;
	end

	// result sink with random stall bursts
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				board.check_result(out_ch.data);
			if (!calm && out_ch.ready && $urandom_range(0, 9) == 0) begin
				gap = $urandom_range(1, 18);
				out_ch.ready <= 1'b0;
				repeat (gap) begin
					@(posedge clk);
				end
				out_ch.ready <= 1'b1;
			end else
				out_ch.ready <= 1'b1;
		end
	end

	task automatic send(mct_pkg::cmd_t c);
		in_ch.data <= c;
		in_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ch.ready);
		board.note_item(c);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18))
				@(posedge clk);
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (100)
			@(posedge clk);
	endtask

	task automatic set_heartbeat(logic [15:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.heartbeat = v;
	endtask

	function automatic mct_pkg::cmd_t mk(logic [1:0] k, logic [15:0] h, logic [15:0] cx,
			logic [31:0] d, logic [2:0] u, logic rp, logic ur, logic [15:0] el);
		mct_pkg::cmd_t c;
		c.kind = k;
		c.handler_id = h;
		c.context_id = cx;
		c.delay = d;
		c.unit_code = u;
		c.repeat_req = rp;
		c.urgent = ur;
		c.elapsed_ms = el;
		return c;
	endfunction

	function automatic mct_pkg::cmd_t rand_item(int unsigned hb);
		mct_pkg::cmd_t c;
		int unsigned sel;
		c = '0;
		sel = $urandom_range(0, 99);
		c.handler_id = 16'($urandom_range(0, 3));
		c.context_id = 16'($urandom_range(0, 3));
		c.unit_code = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(0, 7));
		c.delay = (c.unit_code == 0) ? $urandom_range(0, 3 * hb) : $urandom_range(0, 3);
		c.repeat_req = 1'($urandom_range(0, 1));
		c.urgent = 1'($urandom_range(0, 1));
		c.elapsed_ms = 16'($urandom_range(0, hb));
		if (sel < 35)
			c.kind = mct_pkg::KIND_ADD;
		else if (sel < 50)
			c.kind = mct_pkg::KIND_CANCEL;
		else if (sel < 62)
			c.kind = mct_pkg::KIND_RESTART;
		else
			c.kind = mct_pkg::KIND_TICK;
		if ($urandom_range(0, 19) == 0) begin
			c.handler_id = 16'($urandom);
			c.context_id = 16'($urandom);
			c.delay = $urandom;
			c.elapsed_ms = 16'($urandom);
		end
		return c;
	endfunction

	initial begin
		int unsigned hb;
		arst_n = 1'b0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed part
		send(mk(mct_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		send(mk(mct_pkg::KIND_ADD, 1, 1, 0, 0, 0, 0, 0));
		send(mk(mct_pkg::KIND_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, mct_pkg::UNIT_DAY,
			1, 1, 16'hFFFF));
		send(mk(mct_pkg::KIND_ADD, 2, 3, 1, mct_pkg::UNIT_S, 0, 1, 0));
		send(mk(mct_pkg::KIND_ADD, 4, 5, 2, mct_pkg::UNIT_MIN, 1, 0, 10));
		send(mk(mct_pkg::KIND_ADD, 6, 7, 1, mct_pkg::UNIT_H, 0, 0, 16'hFFFF));
		send(mk(mct_pkg::KIND_ADD, 8, 9, 5, 3'd6, 0, 1, 0));
		send(mk(mct_pkg::KIND_ADD, 9, 9, 300, 0, 1, 1, 100));
		send(mk(mct_pkg::KIND_RESTART, 2, 3, 1000, 0, 0, 0, 0));
		send(mk(mct_pkg::KIND_RESTART, 2, 3, 7, 0, 0, 0, 0));
		send(mk(mct_pkg::KIND_CANCEL, 4, 5, 120000, 0, 0, 0, 0));
		send(mk(mct_pkg::KIND_CANCEL, 4, 5, 120000, 0, 0, 0, 0));
		send(mk(mct_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		send(mk(mct_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < 17; i++)
			send(mk(mct_pkg::KIND_ADD, 16'(i), 16'(i), 32'(1 + i % 3), 0, 1'(i % 2), 0, 0));
		send(mk(mct_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		send(mk(mct_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		set_heartbeat(16'd0);
		send(mk(mct_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		set_heartbeat(16'hFFFF);
		send(mk(mct_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		// random part in phases of heartbeat settings
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: hb = 1;
				1: hb = 65535;
				2: hb = 50;
				default: hb = $urandom_range(2, 2000);
			endcase
			set_heartbeat(hb[15:0]);
			if (p == 5)
				calm = 1'b1;
			for (int n = 0; n < 70; n++)
				send(rand_item(hb > 5000 ? 5000 : hb));
		end
		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/mct_pkg.sv
hw/rtl/mct_stream_if.sv
hw/rtl/mct_conv.sv
hw/rtl/multi_slot_countdown_timer_table.sv
hw/rtl/mct_checker.sv
verif/mct_tb_if.sv
verif/testbench.sv
